// File: hdl/sorted_priority_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent assertion wrappers on clk_i, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while reset is released.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define SPQ_ASSERT(lbl, prop, msg)

`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, transfer types and codes shared by the cell chain and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_BITS  = 16;
  localparam int DATA_BITS = 16;

  localparam int FIELD_W  = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int AGE_W  = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
  localparam int DATA_W = (DATA_BITS < FIELD_W) ? DATA_BITS : FIELD_W;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic               op;
    logic [FIELD_W-1:0] item_age;
    logic [FIELD_W-1:0] item_payload;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  out_age;
    logic [FIELD_W-1:0]  out_payload;
    logic [COUNT_W-1:0]  count;
    logic                empty_flag;
  } out_item_t;

  typedef struct packed {
    logic              push;
    logic [AGE_W-1:0]  age;
    logic [DATA_W-1:0] payload;
  } cell_cmd_t;

  typedef struct packed {
    logic              used;
    logic              ge;
    logic [AGE_W-1:0]  age;
    logic [DATA_W-1:0] payload;
  } cell_link_t;

endpackage

// File: hdl/sorted_priority_queue_unit.sv
// The result of an accepted input transfer is registered and presented in the cycle after it.
// Throughput: one push or pop per cycle while the output is not stalled, set by the
// shift of the cell chain and the registered output stage.
// Reset clears the entry count and the output valid; cell contents are not
// cleared, since only cells below the count are ever read.
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Chain of cells kept in ascending age order; a pop takes the top cell.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spq_pkg::in_item_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spq_pkg::out_item_t out_data_o
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  out_item_t        out_data_q, result_d;
  logic             in_acc;
  logic             full;
  logic             empty;
  logic [IDX_W-1:0] top_idx;
  logic [AGE_W-1:0]  top_age;
  logic [DATA_W-1:0] top_payload;
  cell_cmd_t        cmd;
  cell_link_t       links [CAPACITY];
  cell_link_t       belows [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign top_idx    = IDX_W'(count_q - CNT_W'(1));

  assign cmd.push    = in_acc && (in_data_i.op == OP_PUSH) && !full;
  assign cmd.age     = AGE_W'(in_data_i.item_age);
  assign cmd.payload = DATA_W'(in_data_i.item_payload);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign belows[i] = '{used: 1'b1, ge: 1'b0, age: '0, payload: '0};
    end else begin : g_rest
      assign belows[i] = links[i-1];
    end

    spq_cell u_cell (
      .clk_i   (clk_i),
      .used_i  (count_q > CNT_W'(i)),
      .cmd_i   (cmd),
      .below_i (belows[i]),
      .link_o  (links[i])
    );
  end

  always_comb begin
    top_age     = '0;
    top_payload = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (top_idx == IDX_W'(i)) begin
        top_age     = links[i].age;
        top_payload = links[i].payload;
      end
    end
  end

  always_comb begin
    count_d         = count_q;
    result_d.status = STATUS_OK;
    result_d.out_age     = '0;
    result_d.out_payload = '0;
    if (in_data_i.op == OP_PUSH) begin
      if (full) begin
        result_d.status = STATUS_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        result_d.status = STATUS_EMPTY;
      end else begin
        count_d              = count_q - CNT_W'(1);
        result_d.out_age     = FIELD_W'(top_age);
        result_d.out_payload = FIELD_W'(top_payload);
      end
    end
    result_d.count      = COUNT_W'(count_d);
    result_d.empty_flag = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SPQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY), "Entry count above capacity.")
  `SPQ_ASSERT(a_push_grows, cmd.push |=> count_q == $past(count_q) + CNT_W'(1), "Push did not grow the queue.")
  `SPQ_ASSERT(a_result_follows, in_acc |=> out_valid_o, "Accepted transfer produced no result.")
  `SPQ_ASSERT(a_held_result, (out_valid_o && out_stall_i) |=> $stable(count_q), "Queue changed while the result was stalled.")

endmodule

// File: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on a push it keeps its entry, takes the entry of the cell
// below or takes the new item, so that the chain stays in ascending order.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk_i,
  input  logic               used_i,
  input  spq_pkg::cell_cmd_t  cmd_i,
  input  spq_pkg::cell_link_t below_i,
  output spq_pkg::cell_link_t link_o
);
  import spq_pkg::*;

  logic [AGE_W-1:0]  age_q;
  logic [DATA_W-1:0] payload_q;
  logic              ge;
  logic              take_below;
  logic              take_new;

  assign ge         = used_i && (age_q >= cmd_i.age);
  assign take_below = below_i.ge;
  assign take_new   = !below_i.ge && (ge || (!used_i && below_i.used));

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      if (take_below) begin
        age_q     <= below_i.age;
        payload_q <= below_i.payload;
      end else if (take_new) begin
        age_q     <= cmd_i.age;
        payload_q <= cmd_i.payload;
      end
    end
  end

  assign link_o.used    = used_i;
  assign link_o.ge      = ge;
  assign link_o.age     = age_q;
  assign link_o.payload = payload_q;

endmodule

// File: bench/spq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Watches both channels of the queue, keeps its own sorted copy of the held
// entries, predicts the result of every accepted input transfer and compares
// each result transfer against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module spq_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  spq_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  spq_pkg::out_item_t out_data_i,
  output int                 fail_count_o,
  output int                 pending_count_o,
  output int                 push_count_o,
  output int                 drop_count_o,
  output int                 pop_count_o,
  output int                 empty_pop_count_o
);
  import spq_pkg::*;

  logic [AGE_W-1:0]  held_age [CAPACITY];
  logic [DATA_W-1:0] held_payload [CAPACITY];
  int                held_count;

  out_item_t expected_results [$];

  int fails;
  int pending;
  int pushes;
  int drops;
  int pops;
  int empty_pops;

  assign fail_count_o      = fails;
  assign pending_count_o   = pending;
  assign push_count_o      = pushes;
  assign drop_count_o      = drops;
  assign pop_count_o       = pops;
  assign empty_pop_count_o = empty_pops;

  function automatic out_item_t queue_model_step(input in_item_t item);
    out_item_t         res;
    logic [AGE_W-1:0]  age;
    logic [DATA_W-1:0] payload;
    int                slot;
    res     = '0;
    age     = item.item_age[AGE_W-1:0];
    payload = item.item_payload[DATA_W-1:0];
    slot    = 0;
    if (item.op == OP_PUSH) begin
      pushes++;
      if (held_count >= CAPACITY) begin
        drops++;
        res.status = STATUS_FULL;
      end else begin
        while (slot < held_count && held_age[slot] < age) slot++;
        for (int k = held_count; k > slot; k--) begin
          held_age[k]     = held_age[k-1];
          held_payload[k] = held_payload[k-1];
        end
        held_age[slot]     = age;
        held_payload[slot] = payload;
        held_count++;
        res.status = STATUS_OK;
      end
    end else begin
      pops++;
      if (held_count == 0) begin
        empty_pops++;
        res.status = STATUS_EMPTY;
      end else begin
        held_count--;
        res.status      = STATUS_OK;
        res.out_age     = held_age[held_count];
        res.out_payload = held_payload[held_count];
      end
    end
    res.count      = held_count[COUNT_W-1:0];
    res.empty_flag = (held_count == 0);
    return res;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      fails++;
      if (fails <= 10) begin
        $display("Unexpected result transfer: status %0d age %h payload %h count %0d empty %0b",
                 got.status, got.out_age, got.out_payload, got.count, got.empty_flag);
      end
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status || got.out_age !== want.out_age ||
          got.out_payload !== want.out_payload || got.count !== want.count ||
          got.empty_flag !== want.empty_flag) begin
        fails++;
        if (fails <= 10) begin
          $display("Mismatch: expected status %0d age %h payload %h count %0d empty %0b",
                   want.status, want.out_age, want.out_payload, want.count, want.empty_flag);
          $display("          got      status %0d age %h payload %h count %0d empty %0b",
                   got.status, got.out_age, got.out_payload, got.count, got.empty_flag);
        end
      end
    end
  endtask

  initial begin
    fails      = 0;
    pending    = 0;
    pushes     = 0;
    drops      = 0;
    pops       = 0;
    empty_pops = 0;
    held_count = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      expected_results.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) expected_results.push_back(queue_model_step(in_data_i));
      pending = expected_results.size();
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives push and pop transfers into the queue with random gaps and random
// output stalls, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 21;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      calm;

  int fail_count;
  int pending_count;
  int push_count;
  int drop_count;
  int pop_count;
  int empty_pop_count;
  int cycle_count;

  sorted_priority_queue_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  spq_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_data_i        (out_data),
    .fail_count_o      (fail_count),
    .pending_count_o   (pending_count),
    .push_count_o      (push_count),
    .drop_count_o      (drop_count),
    .pop_count_o       (pop_count),
    .empty_pop_count_o (empty_pop_count)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending_count);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic send_item(input logic op, input logic [FIELD_W-1:0] age,
                           input logic [FIELD_W-1:0] payload);
    logic taken;
    while (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid          <= 1'b1;
    in_data.op           <= op;
    in_data.item_age     <= age;
    in_data.item_payload <= payload;
    do begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end while (!taken);
  endtask

  initial begin
    int          phase_left;
    int          push_pct;
    int          key_mode;
    logic [15:0] age;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    calm      <= 1'b0;
    phase_left = 0;
    push_pct   = 50;
    key_mode   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_POP, 16'hFFFF, 16'hFFFF);
    send_item(OP_PUSH, 16'h0000, 16'h0000);
    send_item(OP_PUSH, 16'hFFFF, 16'hFFFF);
    send_item(OP_PUSH, 16'h8000, 16'h0001);
    send_item(OP_PUSH, 16'h8000, 16'h0002);
    send_item(OP_PUSH, 16'h8000, 16'h0003);
    send_item(OP_PUSH, 16'h7FFF, 16'hA5A5);
    repeat (6) send_item(OP_POP, 16'h0000, 16'h0000);
    send_item(OP_POP, 16'h5A5A, 16'h5A5A);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 40);
        push_pct   = $urandom_range(0, 1) ? 80 : 25;
        key_mode   = $urandom_range(0, 2);
      end
      phase_left--;
      calm <= (n >= 250 && n < 350);
      case (key_mode)
        0: age = 16'($urandom_range(0, 7));
        1: age = 16'($urandom_range(0, 65535));
        default: begin
          case ($urandom_range(0, 3))
            0: age = 16'h0000;
            1: age = 16'hFFFF;
            2: age = 16'h7FFF;
            default: age = 16'h8000;
          endcase
        end
      endcase
      send_item(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, age,
                16'($urandom_range(0, 65535)));
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    do @(negedge clk_i); while (pending_count != 0);
    repeat (4) @(posedge clk_i);

    $display("Covered %0d pushes (%0d dropped on a full queue) and %0d pops", push_count,
             drop_count, pop_count);
    $display("(%0d on an empty queue), with %0d failures.", empty_pop_count, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
